[hdl/beam_profile_centroid_rms_assert.svh]
// Assertion macros shared by the beam profile block.
// Depends on nothing; expects signals clk and arst_n in the using module.
`ifndef BEAM_PROFILE_CENTROID_RMS_ASSERT_SVH
`define BEAM_PROFILE_CENTROID_RMS_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define BPC_ASSERT_IMPLY(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("implication check failed");

// Condition a implies condition c in the next cycle.
`define BPC_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

[hdl/bpc_pkg.sv]
// Shared types, constants and helper functions of the beam profile block.
// Used by bpc_ctrl, bpc_dpath and beam_profile_centroid_rms; depends on nothing.
package bpc_pkg;

	localparam int MAX_SIDE_DEF   = 4096;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int IN_W    = 16;
	localparam int CFG_W   = 13;
	localparam int FIELD_W = 20;
	localparam int M0_W    = 40;
	localparam int M1_W    = 52;
	localparam int M2_W    = 64;
	localparam int WIDE_W  = 128;
	localparam int HALF_W  = 64;
	localparam int T_W     = 104;
	localparam int MM_W    = 2 * M0_W;
	localparam int CNT_W   = 7;

	localparam int MUL_ITER  = 64;
	localparam int DIV_ITER  = 128;
	localparam int SQRT_ITER = 32;

	// Register indexes of the configuration port.
	localparam logic REG_COLUMN_COUNT    = 1'b0;
	localparam logic REG_ROWS_PER_COLUMN = 1'b1;

	typedef logic [3:0] step_t;

	// Steps of the end-of-frame computation.
	localparam step_t STEP_DCX = 4'd0;
	localparam step_t STEP_DCY = 4'd1;
	localparam step_t STEP_MM  = 4'd2;
	localparam step_t STEP_MAX = 4'd3;
	localparam step_t STEP_MBX = 4'd4;
	localparam step_t STEP_DVX = 4'd5;
	localparam step_t STEP_SQX = 4'd6;
	localparam step_t STEP_MAY = 4'd7;
	localparam step_t STEP_MBY = 4'd8;
	localparam step_t STEP_DVY = 4'd9;
	localparam step_t STEP_SQY = 4'd10;
	localparam step_t STEP_LAST = STEP_SQY;

	typedef enum logic [1:0] {
		KIND_MUL,
		KIND_DIV,
		KIND_SQRT
	} kind_t;

	typedef struct packed {
		logic  accept;
		logic  start;
		step_t step;
		logic  load;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic pipe_empty;
		logic mass_zero;
		logic busy;
		logic done;
		logic out_free;
	} sts_t;

	// Which arithmetic unit a step uses.
	function automatic kind_t step_kind(input step_t s);
		kind_t k;
		unique case (s)
			STEP_MM, STEP_MAX, STEP_MBX, STEP_MAY, STEP_MBY: k = KIND_MUL;
			STEP_SQX, STEP_SQY:                              k = KIND_SQRT;
			default:                                         k = KIND_DIV;
		endcase
		return k;
	endfunction

	// Saturate a wide value to a result field.
	function automatic logic [FIELD_W-1:0] sat_field(input logic [WIDE_W-1:0] v);
		logic [FIELD_W-1:0] r;
		if (|v[WIDE_W-1:FIELD_W]) begin
			r = '1;
		end else begin
			r = v[FIELD_W-1:0];
		end
		return r;
	endfunction

	// Saturate a wide quotient to 64 bits.
	function automatic logic [HALF_W-1:0] sat_half(input logic [WIDE_W-1:0] v);
		logic [HALF_W-1:0] r;
		if (|v[WIDE_W-1:HALF_W]) begin
			r = '1;
		end else begin
			r = v[HALF_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/bpc_ctrl.sv]
// Controller of the beam profile block: frame phase and end-of-frame step sequencing.
// Depends on bpc_pkg; drives the datapath through cmd_t and watches sts_t.
module bpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  bpc_pkg::sts_t sts,
	output bpc_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_ACC   = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]     state_q;
	bpc_pkg::step_t step_q;

	// Commands follow directly from the state.
	always_comb begin
		cmd.accept = (state_q == ST_ACC);
		cmd.start  = (state_q == ST_ISSUE);
		cmd.step   = step_q;
		cmd.load   = (state_q == ST_OUT) && sts.out_free;
	end

	// Sequence the frame: accumulate, drain the pipeline, run the steps unless the frame is empty, hand off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= bpc_pkg::STEP_DCX;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (sts.frame_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.pipe_empty) begin
						step_q  <= bpc_pkg::STEP_DCX;
						state_q <= sts.mass_zero ? ST_OUT : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sts.done) begin
						if (step_q == bpc_pkg::STEP_LAST) begin
							state_q <= ST_OUT;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

[hdl/bpc_dpath.sv]
// Datapath of the beam profile block: index counters, moment pipeline,
// iterative multiply/divide/square-root engine and the output register. Depends on bpc_pkg.
module bpc_dpath #(
	parameter int MAX_SIDE   = bpc_pkg::MAX_SIDE_DEF,
	parameter int PIXEL_BITS = bpc_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = bpc_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpc_pkg::cmd_t                cmd,
	output bpc_pkg::sts_t                sts,
	input  logic                         cfg_we,
	input  logic                         cfg_addr,
	input  logic [bpc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         s_tvalid,
	input  logic [bpc_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [4*bpc_pkg::FIELD_W-1:0] m_tdata,
	output logic                         m_tuser
);

	localparam int IDX_W = $clog2(MAX_SIDE);
	localparam int LIM_W = $clog2(MAX_SIDE + 1);
	localparam int SQ_W  = 2 * IDX_W;
	localparam int P1_W  = PIXEL_BITS + IDX_W;
	localparam int P2_W  = PIXEL_BITS + SQ_W;
	localparam int WW    = bpc_pkg::WIDE_W;
	localparam int HW    = bpc_pkg::HALF_W;
	localparam int FW    = bpc_pkg::FIELD_W;

	// Clamp a written side length to 1..MAX_SIDE.
	function automatic logic [LIM_W-1:0] side_limit(input logic [bpc_pkg::CFG_W-1:0] v);
		logic [LIM_W-1:0] r;
		if (v == '0) begin
			r = LIM_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = LIM_W'(MAX_SIDE);
		end else begin
			r = LIM_W'(v);
		end
		return r;
	endfunction

	logic [LIM_W-1:0] col_lim_q, row_lim_q;
	logic [IDX_W-1:0] col_q, row_q;
	logic             accept, col_end, frame_end;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_lim_q <= LIM_W'(MAX_SIDE);
			row_lim_q <= LIM_W'(MAX_SIDE);
		end else if (cfg_we) begin
			if (cfg_addr == bpc_pkg::REG_COLUMN_COUNT) begin
				col_lim_q <= side_limit(cfg_wdata);
			end else begin
				row_lim_q <= side_limit(cfg_wdata);
			end
		end
	end

	// Scan position of the accepted pixel.
	assign accept    = s_tvalid && cmd.accept;
	assign col_end   = (LIM_W'(row_q) + LIM_W'(1)) >= row_lim_q;
	assign frame_end = accept && col_end && ((LIM_W'(col_q) + LIM_W'(1)) >= col_lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= col_q + IDX_W'(1);
				row_q <= '0;
			end else begin
				row_q <= row_q + IDX_W'(1);
			end
		end
	end

	// Moment pipeline: operands, first products and squares, second products.
	logic                  vld_s1, vld_s2, vld_s3;
	logic [PIXEL_BITS-1:0] v_s1, v_s2;
	logic [IDX_W-1:0]      c_s1, r_s1;
	logic [P1_W-1:0]       vc_s2, vr_s2, vc_s3, vr_s3;
	logic [SQ_W-1:0]       cc_s2, rr_s2;
	logic [P2_W-1:0]       vcc_s3, vrr_s3;
	logic [PIXEL_BITS-1:0] v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1   <= s_tdata[PIXEL_BITS-1:0];
		c_s1   <= col_q;
		r_s1   <= row_q;
		v_s2   <= v_s1;
		vc_s2  <= P1_W'(v_s1) * P1_W'(c_s1);
		vr_s2  <= P1_W'(v_s1) * P1_W'(r_s1);
		cc_s2  <= SQ_W'(c_s1) * SQ_W'(c_s1);
		rr_s2  <= SQ_W'(r_s1) * SQ_W'(r_s1);
		v_s3   <= v_s2;
		vc_s3  <= vc_s2;
		vr_s3  <= vr_s2;
		vcc_s3 <= P2_W'(v_s2) * P2_W'(cc_s2);
		vrr_s3 <= P2_W'(v_s2) * P2_W'(rr_s2);
	end

	// Frame accumulators, cleared when the result is handed off.
	logic [bpc_pkg::M0_W-1:0] m0_q;
	logic [bpc_pkg::M1_W-1:0] m1x_q, m1y_q;
	logic [bpc_pkg::M2_W-1:0] m2x_q, m2y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_q  <= '0;
			m1x_q <= '0;
			m1y_q <= '0;
			m2x_q <= '0;
			m2y_q <= '0;
		end else if (cmd.load) begin
			m0_q  <= '0;
			m1x_q <= '0;
			m1y_q <= '0;
			m2x_q <= '0;
			m2y_q <= '0;
		end else if (vld_s3) begin
			m0_q  <= m0_q + bpc_pkg::M0_W'(v_s3);
			m1x_q <= m1x_q + bpc_pkg::M1_W'(vc_s3);
			m1y_q <= m1y_q + bpc_pkg::M1_W'(vr_s3);
			m2x_q <= m2x_q + bpc_pkg::M2_W'(vcc_s3);
			m2y_q <= m2y_q + bpc_pkg::M2_W'(vrr_s3);
		end
	end

	// Iterative engine: shift-add multiply, restoring divide, bitwise square root.
	logic                      busy_q, done_q;
	logic [bpc_pkg::CNT_W-1:0] cnt_q;
	bpc_pkg::step_t            step_q;
	bpc_pkg::kind_t            kind_q;
	logic [WW-1:0]             acc_q, mcand_q;
	logic [HW-1:0]             mplier_q;
	logic [WW-1:0]             rem_q, nq_q, den_q;
	logic [HW-1:0]             sv_q, sr_q, sbit_q;
	logic [bpc_pkg::MM_W-1:0]  mm_q;
	logic [bpc_pkg::T_W-1:0]   ta_q, tb_q;
	logic [HW-1:0]             var_q;
	logic [FW-1:0]             cx_q, cy_q, sx_q, sy_q;

	logic [WW:0]   div_t, div_diff;
	logic          div_ge;
	logic [HW-1:0] sq_trial;
	logic          sq_ge;
	logic [WW-1:0] mul_sum;
	logic [WW-1:0] var_num;
	bpc_pkg::kind_t start_kind;

	assign start_kind = bpc_pkg::step_kind(cmd.step);
	assign mul_sum    = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign div_t      = {rem_q, nq_q[WW-1]};
	assign div_diff   = div_t - {1'b0, den_q};
	assign div_ge     = div_t >= {1'b0, den_q};
	assign sq_trial   = sr_q + sbit_q;
	assign sq_ge      = sv_q >= sq_trial;
	assign var_num    = (ta_q >= tb_q) ? (WW'(ta_q - tb_q) << (2 * FRAC_BITS)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (cmd.start) begin
				busy_q <= 1'b1;
				unique case (start_kind)
					bpc_pkg::KIND_MUL:  cnt_q <= bpc_pkg::CNT_W'(bpc_pkg::MUL_ITER - 1);
					bpc_pkg::KIND_DIV:  cnt_q <= bpc_pkg::CNT_W'(bpc_pkg::DIV_ITER - 1);
					bpc_pkg::KIND_SQRT: cnt_q <= bpc_pkg::CNT_W'(bpc_pkg::SQRT_ITER - 1);
					default:            cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - bpc_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Operand load and one iteration per cycle.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			step_q   <= cmd.step;
			kind_q   <= start_kind;
			acc_q    <= '0;
			rem_q    <= '0;
			sr_q     <= '0;
			sbit_q   <= HW'(1) << (HW - 2);
			sv_q     <= var_q;
			unique case (cmd.step)
				bpc_pkg::STEP_MM: begin
					mcand_q <= WW'(m0_q);  mplier_q <= HW'(m0_q);
				end
				bpc_pkg::STEP_MAX: begin
					mcand_q <= WW'(m2x_q); mplier_q <= HW'(m0_q);
				end
				bpc_pkg::STEP_MBX: begin
					mcand_q <= WW'(m1x_q); mplier_q <= HW'(m1x_q);
				end
				bpc_pkg::STEP_MAY: begin
					mcand_q <= WW'(m2y_q); mplier_q <= HW'(m0_q);
				end
				bpc_pkg::STEP_MBY: begin
					mcand_q <= WW'(m1y_q); mplier_q <= HW'(m1y_q);
				end
				bpc_pkg::STEP_DCX: begin
					nq_q <= WW'(m1x_q) << FRAC_BITS; den_q <= WW'(m0_q);
				end
				bpc_pkg::STEP_DCY: begin
					nq_q <= WW'(m1y_q) << FRAC_BITS; den_q <= WW'(m0_q);
				end
				bpc_pkg::STEP_DVX, bpc_pkg::STEP_DVY: begin
					nq_q <= var_num; den_q <= WW'(mm_q);
				end
				default: begin
				end
			endcase
		end else if (busy_q) begin
			unique case (kind_q)
				bpc_pkg::KIND_MUL: begin
					acc_q    <= mul_sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				bpc_pkg::KIND_DIV: begin
					rem_q <= div_ge ? div_diff[WW-1:0] : div_t[WW-1:0];
					nq_q  <= {nq_q[WW-2:0], div_ge};
				end
				bpc_pkg::KIND_SQRT: begin
					if (sq_ge) begin
						sv_q <= sv_q - sq_trial;
						sr_q <= (sr_q >> 1) + sbit_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
				default: begin
				end
			endcase
		end
	end

	// Write the finished step into its destination.
	always_ff @(posedge clk) begin
		if (done_q) begin
			unique case (step_q)
				bpc_pkg::STEP_DCX: cx_q <= bpc_pkg::sat_field(nq_q);
				bpc_pkg::STEP_DCY: cy_q <= bpc_pkg::sat_field(nq_q);
				bpc_pkg::STEP_MM:  mm_q <= acc_q[bpc_pkg::MM_W-1:0];
				bpc_pkg::STEP_MAX, bpc_pkg::STEP_MAY: ta_q <= acc_q[bpc_pkg::T_W-1:0];
				bpc_pkg::STEP_MBX, bpc_pkg::STEP_MBY: tb_q <= acc_q[bpc_pkg::T_W-1:0];
				bpc_pkg::STEP_DVX, bpc_pkg::STEP_DVY: var_q <= bpc_pkg::sat_half(nq_q);
				bpc_pkg::STEP_SQX: sx_q <= bpc_pkg::sat_field(WW'(sr_q));
				bpc_pkg::STEP_SQY: sy_q <= bpc_pkg::sat_field(WW'(sr_q));
				default: begin
				end
			endcase
		end
	end

	// Output register; an empty frame gives zero fields.
	logic                m_tvalid_q, m_tuser_q;
	logic [4*FW-1:0]     m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tuser_q <= (m0_q == '0);
			m_tdata_q <= (m0_q == '0) ? '0 : {sy_q, sx_q, cy_q, cx_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		sts.frame_end  = frame_end;
		sts.pipe_empty = !(vld_s1 || vld_s2 || vld_s3);
		sts.mass_zero  = (m0_q == '0);
		sts.busy       = busy_q;
		sts.done       = done_q;
		sts.out_free   = !m_tvalid_q || m_tready;
	end

endmodule

[hdl/beam_profile_centroid_rms.sv]
// Beam profile centroid and RMS width, top level.
// Input: s_tvalid/s_tready/s_tdata, one pixel intensity per transaction, column-major.
// Output: m_tvalid/m_tready/m_tdata/m_tuser, one transaction per frame.
// Configuration: cfg_we/cfg_addr/cfg_wdata, index 0 column count, 1 rows per column.
// Pixels are accepted at one per cycle while a frame is being accumulated.
// After the last pixel of a frame the input stalls while the result is computed:
// the pipeline drains, then eleven steps run on one shared iterative unit
// (shift-add multiply, restoring divide, bitwise square root) when the total
// intensity is nonzero; when it is zero, the steps are skipped.
// The result then sits in the output register; a new frame is taken while it waits.
// If the receiver still holds the previous result, the block waits before loading.
// Reset clears the counters and sums and sets both sizes to MAX_SIDE.
// Depends on bpc_pkg, bpc_ctrl, bpc_dpath and the assertion header.
`include "beam_profile_centroid_rms_assert.svh"

module beam_profile_centroid_rms #(
	parameter int MAX_SIDE   = bpc_pkg::MAX_SIDE_DEF,
	parameter int PIXEL_BITS = bpc_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS  = bpc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [bpc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pixel_value[15:0]
	input  logic [bpc_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// center_x[19:0], center_y[39:20], sigma_x[59:40], sigma_y[79:60]
	output logic [4*bpc_pkg::FIELD_W-1:0] m_tdata,
	// empty_frame[0]
	output logic                          m_tuser
);

	bpc_pkg::cmd_t cmd;
	bpc_pkg::sts_t sts;

	bpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	bpc_dpath #(
		.MAX_SIDE   (MAX_SIDE),
		.PIXEL_BITS (PIXEL_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	assign s_tready = cmd.accept;

	// An empty frame carries zero values.
	`BPC_ASSERT_IMPLY(a_empty_zero, m_tvalid && m_tuser, m_tdata == '0)
	// Pixels are never taken while the engine works.
	`BPC_ASSERT_IMPLY(a_no_accept_busy, s_tready, !sts.busy)
	// A step start puts the engine to work.
	`BPC_ASSERT_NEXT(a_start_busy, cmd.start, sts.busy)

endmodule
